@@ rtl/fmbs_pkg.sv @@
package fmbs_pkg;

  localparam int MAX_SYMBOLS = 65536;
  localparam int NUM_CODES   = 5;
  localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int CMD_W   = 2;
  localparam int SYM_W   = 3;
  localparam int IDX_W   = 16;
  localparam int LOW_W   = 17;
  localparam int UP_W    = 17;
  localparam int LF_W    = 16;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXTEND = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LF     = 2'd3;

  localparam logic [SYM_W-1:0] SYM_END = 3'd0;
  localparam logic [SYM_W-1:0] SYM_A   = 3'd1;
  localparam logic [SYM_W-1:0] SYM_C   = 3'd2;
  localparam logic [SYM_W-1:0] SYM_G   = 3'd3;
  localparam logic [SYM_W-1:0] SYM_T   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef logic [NUM_CODES-1:0][CNT_W-1:0] totals_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    totals_t          occ;
  } row_t;

  function automatic logic [SYM_W-1:0] fold_code(input logic [SYM_W-1:0] s);
    return (s <= SYM_T) ? s : SYM_END;
  endfunction

  function automatic logic [CNT_W-1:0] pred_count(input totals_t t,
                                                  input logic [SYM_W-1:0] c);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < NUM_CODES; k++) begin
      if (k < int'(c)) sum = sum + t[k];
    end
    return sum;
  endfunction

endpackage

@@ rtl/fmbs_req_if.sv @@
interface fmbs_req_if;
  logic                         valid;
  logic                         ready;
  logic [fmbs_pkg::CMD_W-1:0]   cmd;
  logic [fmbs_pkg::SYM_W-1:0]   symbol;
  logic [fmbs_pkg::IDX_W-1:0]   index;

  modport source (output valid, cmd, symbol, index, input ready);
  modport sink   (input valid, cmd, symbol, index, output ready);
endinterface

@@ rtl/fmbs_rsp_if.sv @@
interface fmbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fmbs_pkg::LOW_W-1:0]    lower;
  logic signed [fmbs_pkg::UP_W-1:0] upper;
  logic                          empty_res;
  logic [fmbs_pkg::LF_W-1:0]     lf_position;
  logic [fmbs_pkg::STAT_W-1:0]   status;

  modport source (output valid, lower, upper, empty_res, lf_position, status, input ready);
  modport sink   (input valid, lower, upper, empty_res, lf_position, status, output ready);
endinterface

@@ rtl/fmbs_ram.sv @@
module fmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ rtl/fm_index_backward_search_unit.sv @@
// fm-index backward search engine over a dna bwt ($ A C G T coded 0..4)
// req channel (valid/ready) carries cmd, symbol and index; rsp channel
// (valid/ready) returns one result per request: the current interval
// (lower, upper, empty_res), lf_position and status.
// load appends one bwt symbol and its row of inclusive occurrence
// counts unless full; start and extend narrow the suffix interval, pattern
// taken last symbol first; lf maps a bwt position to its row.
// bwt symbols and occurrence rows share one memory row per position, so
// every lookup is a single registered read.
// load, start and lf go through S_FIN only; extend goes through S_RD2 and
// then S_FIN, since its two occurrence lookups go through the one read
// port one after the other; the result is registered in S_FIN.
// a request is taken only while no earlier one is in flight; the result sits
// in an output register, so the next request is taken while it waits, and
// it stalls only in its last cycle when the receiver has not taken the
// previous result.
// reset clears the symbol totals, the loaded length and the interval;
// the memory is not cleared; reads of unloaded positions go unused.
module fm_index_backward_search_unit (
  input  logic         clk,
  input  logic         rst,
  fmbs_req_if.sink     req,
  fmbs_rsp_if.source   rsp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD2  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic                          zero;
    logic [fmbs_pkg::ADDR_W-1:0]   addr;
  } occ_ref_t;

  function automatic occ_ref_t occ_ref(input logic signed [fmbs_pkg::CNT_W:0] pos,
                                       input logic [fmbs_pkg::CNT_W-1:0] len);
    occ_ref_t r;
    logic signed [fmbs_pkg::CNT_W:0] slen;
    slen   = $signed({1'b0, len});
    r.zero = (pos < 0) || (len == '0);
    if (pos >= slen) r.addr = fmbs_pkg::ADDR_W'(len - 1'b1);
    else             r.addr = fmbs_pkg::ADDR_W'(pos);
    return r;
  endfunction

  state_t                            state;
  logic [fmbs_pkg::CMD_W-1:0]        cmd_q;
  logic [fmbs_pkg::SYM_W-1:0]        sym_q;
  logic [fmbs_pkg::IDX_W-1:0]        idx_q;
  logic                              zero_lo;
  logic                              zero_hi;
  logic [fmbs_pkg::CNT_W-1:0]        occ_lo;
  fmbs_pkg::totals_t                 totals;
  logic [fmbs_pkg::CNT_W-1:0]        len;
  logic [fmbs_pkg::CNT_W-1:0]        low;
  logic signed [fmbs_pkg::CNT_W-1:0] high;

  logic                              acc;
  logic [fmbs_pkg::SYM_W-1:0]        sym_in;
  occ_ref_t                          ref_lo;
  occ_ref_t                          ref_hi;
  logic                              re;
  logic [fmbs_pkg::ADDR_W-1:0]       raddr;
  fmbs_pkg::row_t                    rd_row;
  fmbs_pkg::row_t                    wr_row;
  logic                              we;
  logic                              publish;
  fmbs_pkg::totals_t                 totals_inc;
  logic [fmbs_pkg::CNT_W-1:0]        pred_c;
  logic [fmbs_pkg::CNT_W-1:0]        occ_hi;
  logic [fmbs_pkg::CNT_W-1:0]        low_next;
  logic signed [fmbs_pkg::CNT_W-1:0] high_next;
  logic signed [fmbs_pkg::CNT_W:0]   high_sum;
  logic [fmbs_pkg::CNT_W:0]          lf_sum;
  logic [fmbs_pkg::LF_W-1:0]         lf_res;
  logic [fmbs_pkg::STAT_W-1:0]       stat_res;
  logic                              full;
  logic                              upd_int;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign sym_in    = fmbs_pkg::fold_code(req.symbol);
  assign publish   = (state == S_FIN) && (!rsp.valid || rsp.ready);
  assign full      = (len == fmbs_pkg::CNT_W'(fmbs_pkg::MAX_SYMBOLS));

  assign ref_lo = occ_ref($signed({1'b0, low} - 1'b1), len);
  assign ref_hi = occ_ref({high[fmbs_pkg::CNT_W-1], high}, len);

  always_comb begin
    re    = 1'b0;
    raddr = ref_hi.addr;
    if (state == S_IDLE) begin
      re    = acc && (req.cmd == fmbs_pkg::CMD_LF || req.cmd == fmbs_pkg::CMD_EXTEND);
      raddr = (req.cmd == fmbs_pkg::CMD_LF) ? fmbs_pkg::ADDR_W'(req.index) : ref_lo.addr;
    end else if (state == S_RD2) begin
      re = 1'b1;
    end
  end

  always_comb begin
    totals_inc        = totals;
    totals_inc[sym_q] = totals[sym_q] + 1'b1;
  end

  assign wr_row.sym = sym_q;
  assign wr_row.occ = totals_inc;
  assign we         = publish && (cmd_q == fmbs_pkg::CMD_LOAD) && !full;

  fmbs_ram #(
    .WIDTH ($bits(fmbs_pkg::row_t)),
    .DEPTH (fmbs_pkg::MAX_SYMBOLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fmbs_pkg::ADDR_W'(len)),
    .wdata (wr_row),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_row)
  );

  assign pred_c = fmbs_pkg::pred_count(totals, sym_q);
  assign occ_hi = zero_hi ? '0 : rd_row.occ[sym_q];

  always_comb begin
    low_next  = low;
    high_sum  = {high[fmbs_pkg::CNT_W-1], high};
    lf_sum    = '0;
    stat_res  = fmbs_pkg::STAT_OK;
    upd_int   = 1'b0;
    case (cmd_q)
      fmbs_pkg::CMD_START: begin
        upd_int  = 1'b1;
        low_next = pred_c;
        high_sum = $signed({1'b0, pred_c} + {1'b0, totals[sym_q]} - 1'b1);
      end
      fmbs_pkg::CMD_EXTEND: begin
        upd_int  = 1'b1;
        low_next = pred_c + occ_lo;
        high_sum = $signed({1'b0, pred_c} + {1'b0, occ_hi} - 1'b1);
      end
      fmbs_pkg::CMD_LF: begin
        if ({1'b0, idx_q} >= len) begin
          stat_res = fmbs_pkg::STAT_RANGE;
        end else if (rd_row.sym != fmbs_pkg::SYM_END) begin
          lf_sum = {1'b0, fmbs_pkg::pred_count(totals, rd_row.sym)}
                 + {1'b0, rd_row.occ[rd_row.sym]} - 1'b1;
        end
      end
      default: begin
        if (full) stat_res = fmbs_pkg::STAT_FULL;
      end
    endcase
    high_next = fmbs_pkg::CNT_W'(high_sum);
    lf_res    = fmbs_pkg::LF_W'(lf_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      totals    <= '0;
      len       <= '0;
      low       <= '0;
      high      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) state <= (req.cmd == fmbs_pkg::CMD_EXTEND) ? S_RD2 : S_FIN;
        end
        S_RD2: state <= S_FIN;
        S_FIN: begin
          if (publish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (publish) begin
        rsp.valid <= 1'b1;
        if (upd_int) begin
          low  <= low_next;
          high <= high_next;
        end
        if (we) begin
          totals <= totals_inc;
          len    <= len + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_q   <= req.cmd;
      sym_q   <= sym_in;
      idx_q   <= req.index;
      zero_lo <= ref_lo.zero;
    end
    if (state == S_RD2) begin
      occ_lo  <= zero_lo ? '0 : rd_row.occ[sym_q];
      zero_hi <= ref_hi.zero;
    end
    if (publish) begin
      rsp.lower       <= fmbs_pkg::LOW_W'(upd_int ? low_next : low);
      rsp.upper       <= fmbs_pkg::UP_W'(upd_int ? high_next : high);
      rsp.empty_res   <= upd_int
        ? ($signed({1'b0, low_next}) > $signed({high_next[fmbs_pkg::CNT_W-1], high_next}))
        : ($signed({1'b0, low}) > $signed({high[fmbs_pkg::CNT_W-1], high}));
      rsp.lf_position <= lf_res;
      rsp.status      <= stat_res;
    end
  end

endmodule
